// ===== rtl/efcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efcs_pkg
// shared types and codes for the event ring with critical slots
// ----------------------------------------------------------------------------
package efcs_pkg;
  localparam logic [1:0] MODE_PUBLISH  = 2'd0;
  localparam logic [1:0] MODE_TAKE     = 2'd1;
  localparam logic [1:0] MODE_CRITICAL = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

  // one ring entry as it moves along the cell chain
  typedef struct packed {
    logic [3:0]  etype;
    logic [31:0] seq;
    logic [31:0] snap;
    logic        consumed;
  } ring_meta_t;
endpackage

// ===== rtl/efcs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efcs_cell
// one ring cell: holds an entry, loads, shifts from its neighbor, or marks
// ----------------------------------------------------------------------------
module efcs_cell import efcs_pkg::*; #(
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    shift,
  input  logic                    load,
  input  logic                    mark,
  input  ring_meta_t              meta_in,
  input  logic [PAYLOAD_BITS-1:0] pay_in,
  input  ring_meta_t              nb_meta,
  input  logic [PAYLOAD_BITS-1:0] nb_pay,
  output ring_meta_t              meta,
  output logic [PAYLOAD_BITS-1:0] pay
);
  always_ff @(posedge clk) begin
    if (load) begin
      meta <= meta_in;
      pay  <= pay_in;
    end else if (shift) begin
      meta <= nb_meta;
      pay  <= nb_pay;
    end else if (mark) begin
      meta.consumed <= 1'b1;
    end
  end
endmodule

// ===== rtl/event_fifo_with_critical_slots.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_fifo_with_critical_slots
// event ring as a shifting chain of cells plus per-type critical slots
// ----------------------------------------------------------------------------
// latency, accept to result valid, follows these steps: publish loads a cell,
//   first dropping the oldest entry when the ring is full; take-next pops
//   entries, skipping consumed ones; an undefined mode gives an empty result;
//   take-critical scans all type slots, then if one is pending marks its ring entry
// throughput: one request at a time; the slot scan and ring match walks set it
// reset: rst synchronous active high clears counters, pending bits and out_valid;
//   ring cells and the result fields hold no reset
// ----------------------------------------------------------------------------
module event_fifo_with_critical_slots import efcs_pkg::*; #(
  parameter int RING_DEPTH   = 16,
  parameter int TYPE_SLOTS   = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [3:0]  evt_type,
  input  logic        critical_flag,
  input  logic [31:0] event_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [3:0]  out_type,
  output logic [31:0] out_sequence,
  output logic [31:0] out_overflow_snapshot,
  output logic [31:0] out_payload
);
  localparam int RW = $clog2(RING_DEPTH + 1);
  localparam int SW = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_OVF, S_PUB, S_TAKE, S_SCAN, S_MATCH, S_OUT
  } state_t;

  state_t state;
  logic [3:0] ovf_type;
  // cell 0 is the head; entries shift toward cell 0 on a pop
  ring_meta_t              cmeta [RING_DEPTH];
  logic [PAYLOAD_BITS-1:0] cpay  [RING_DEPTH];
  logic [RING_DEPTH-1:0]   c_load, c_mark;
  logic                    c_shift;
  ring_meta_t              ld_meta;
  logic [RW-1:0]  count;
  logic [31:0]    last_seq, ovf_total;
  logic [63:0]    pub_cnt;
  logic [PAYLOAD_BITS-1:0] s_pay [TYPE_SLOTS];
  logic [31:0]    s_seq [TYPE_SLOTS];
  logic [31:0]    s_snap [TYPE_SLOTS];
  logic [63:0]    s_ord [TYPE_SLOTS];
  logic [TYPE_SLOTS-1:0] pending;
  // request registers
  logic [3:0] r_type;
  logic       r_crit;
  logic [PAYLOAD_BITS-1:0] r_pay;
  // scan and match
  logic [SW:0]  scan_i;
  logic [SW-1:0] best_i;
  logic         found;
  logic [63:0]  best_ord;
  logic [RW-1:0] mi;
  logic [31:0]  mseq;
  logic [31:0]  seq_inc;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign seq_inc  = (last_seq == SEQ_MAX) ? 32'd1 : last_seq + 32'd1;

  genvar g;
  generate
    for (g = 0; g < RING_DEPTH; g++) begin : g_cell
      ring_meta_t              nbm;
      logic [PAYLOAD_BITS-1:0] nbp;
      if (g == RING_DEPTH - 1) begin : g_end
        assign nbm = cmeta[g];
        assign nbp = cpay[g];
      end else begin : g_mid
        assign nbm = cmeta[g+1];
        assign nbp = cpay[g+1];
      end
      efcs_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
        .clk(clk), .shift(c_shift), .load(c_load[g]), .mark(c_mark[g]),
        .meta_in(ld_meta), .pay_in(r_pay), .nb_meta(nbm), .nb_pay(nbp),
        .meta(cmeta[g]), .pay(cpay[g])
      );
    end
  endgenerate

  // chain control
  always_comb begin
    c_shift = 1'b0;
    c_load  = '0;
    c_mark  = '0;
    ld_meta = '{etype: r_type, seq: seq_inc, snap: ovf_total, consumed: 1'b0};
    if (state == S_OVF) c_shift = 1'b1;
    if (state == S_TAKE && count != '0) c_shift = 1'b1;
    if (state == S_PUB) c_load[count[PW-1:0]] = 1'b1;
    if (state == S_MATCH && mi < count && cmeta[mi[PW-1:0]].seq == mseq)
      c_mark[mi[PW-1:0]] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ovf_type <= 4'd15; count <= '0; last_seq <= '0;
      ovf_total <= '0; pub_cnt <= '0; pending <= '0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) ovf_type <= cfg_wdata;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          r_type <= evt_type; r_crit <= critical_flag;
          r_pay <= PAYLOAD_BITS'(event_payload);
          ok <= 1'b0; out_type <= '0; out_sequence <= '0;
          out_overflow_snapshot <= '0; out_payload <= '0;
          scan_i <= '0; found <= 1'b0; best_i <= '0; best_ord <= '0;
          unique case (mode)
            MODE_PUBLISH:  state <= (count == RW'(RING_DEPTH)) ? S_OVF : S_PUB;
            MODE_TAKE:     state <= S_TAKE;
            MODE_CRITICAL: state <= S_SCAN;
            default:       state <= S_OUT;
          endcase
        end
        S_OVF: begin
          // drop oldest, count overflow, synthesize overflow slot event
          count <= count - RW'(1);
          ovf_total <= (ovf_total == SEQ_MAX) ? ovf_total : ovf_total + 32'd1;
          last_seq <= seq_inc;
          if (32'(ovf_type) < TYPE_SLOTS) begin
            pub_cnt <= pub_cnt + 64'd1;
            s_pay[SW'(ovf_type)] <= r_pay;
            s_seq[SW'(ovf_type)] <= seq_inc;
            s_snap[SW'(ovf_type)] <=
              (ovf_total == SEQ_MAX) ? ovf_total : ovf_total + 32'd1;
            s_ord[SW'(ovf_type)] <= pub_cnt + 64'd1;
            pending[SW'(ovf_type)] <= 1'b1;
          end
          state <= S_PUB;
        end
        S_PUB: begin
          count <= count + RW'(1);
          last_seq <= seq_inc;
          if (r_crit && 32'(r_type) < TYPE_SLOTS) begin
            pub_cnt <= pub_cnt + 64'd1;
            s_pay[SW'(r_type)] <= r_pay;
            s_seq[SW'(r_type)] <= seq_inc;
            s_snap[SW'(r_type)] <= ovf_total;
            s_ord[SW'(r_type)] <= pub_cnt + 64'd1;
            pending[SW'(r_type)] <= 1'b1;
          end
          ok <= 1'b1;
          state <= S_OUT;
        end
        S_TAKE: begin
          // pop one entry per cycle, skipping those delivered out of band
          if (count == '0) state <= S_OUT;
          else begin
            count <= count - RW'(1);
            if (!cmeta[0].consumed) begin
              ok <= 1'b1; out_type <= cmeta[0].etype; out_sequence <= cmeta[0].seq;
              out_overflow_snapshot <= cmeta[0].snap;
              out_payload <= 32'(cpay[0]);
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (scan_i == (SW+1)'(TYPE_SLOTS)) begin
            if (found) begin
              pending[best_i] <= 1'b0;
              ok <= 1'b1; out_type <= 4'(best_i); out_sequence <= s_seq[best_i];
              out_overflow_snapshot <= s_snap[best_i];
              out_payload <= 32'(s_pay[best_i]);
              mseq <= s_seq[best_i]; mi <= '0;
              state <= S_MATCH;
            end else state <= S_OUT;
          end else begin
            if (pending[scan_i[SW-1:0]] &&
                (!found || s_ord[scan_i[SW-1:0]] < best_ord)) begin
              found <= 1'b1; best_i <= scan_i[SW-1:0];
              best_ord <= s_ord[scan_i[SW-1:0]];
            end
            scan_i <= scan_i + (SW+1)'(1);
          end
        end
        S_MATCH: begin
          if (mi >= count || |c_mark) state <= S_OUT;
          else mi <= mi + RW'(1);
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/efcs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efcs_checker
// port-level checks for the event ring
// ----------------------------------------------------------------------------
module efcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic [31:0] out_sequence
);
  // no new request while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while result pending");
  // out_valid stays low just after a request is accepted
  a_res: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("early result");
  // an empty result carries no event
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> out_sequence == 32'd0)
    else $error("sequence on empty result");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_sequence))
    else $error("result dropped");
endmodule

bind event_fifo_with_critical_slots efcs_checker u_efcs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .ok(ok),
  .out_sequence(out_sequence)
);
